// File: rtl/core/mtaw_pkg.sv
// ----------------------------------------------------------------------------
// mtaw_pkg
// Shared constants and types for the adaptive multitaper weighting block.
// ----------------------------------------------------------------------------
package mtaw_pkg;
	localparam int NUM_BINS   = 64;
	localparam int MAX_TAPERS = 7;
	localparam int RUNS       = 3;
	localparam int BIN_W      = $clog2(NUM_BINS);
	localparam int TAP_W      = 3;
	localparam int RUN_W      = (RUNS > 1) ? $clog2(RUNS) : 1;
	localparam int SMP_DEPTH  = MAX_TAPERS * NUM_BINS;
	localparam int SMP_AW     = $clog2(SMP_DEPTH);
	localparam int CFG_IDX_W  = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPERS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAMBDA0 = 3'd1;
	localparam logic [15:0] ONE_Q15 = 16'd32768;
	localparam logic [23:0] KMAX = 24'hFFFFFF;

	typedef struct packed {
		logic [TAP_W-1:0] taper;
		logic [BIN_W-1:0] bin;
		logic [31:0]      power;
		logic             set_done;
	} in_item_t;

	typedef struct packed {
		logic [BIN_W-1:0] out_bin;
		logic [31:0]      psd;
		logic             zero_div;
		logic             final_bin;
	} out_item_t;

	// queue entry between front and back: store write plus start flag
	typedef struct packed {
		logic              wr;
		logic [SMP_AW-1:0] addr;
		logic [31:0]       power;
		logic              start;
	} cmd_t;
endpackage

// File: rtl/core/mtaw_if.sv
// ----------------------------------------------------------------------------
// mtaw_in_if / mtaw_out_if / mtaw_cfg_if
// Valid/ready channels of the block.
// ----------------------------------------------------------------------------
interface mtaw_in_if;
	import mtaw_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mtaw_out_if;
	import mtaw_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mtaw_cfg_if;
	import mtaw_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/mtaw_ram.sv
// ----------------------------------------------------------------------------
// mtaw_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mtaw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/mtaw_front.sv
// ----------------------------------------------------------------------------
// mtaw_front
// Accept input items, range check them and push store commands to the queue.
// ----------------------------------------------------------------------------
module mtaw_front (
	mtaw_in_if.sink         in_ch,
	output mtaw_pkg::cmd_t  q_wdata,
	output logic            q_push,
	input  logic            q_full
);
	import mtaw_pkg::*;

	logic ok;

	assign in_ch.ready = !q_full;
	assign q_push = in_ch.valid && !q_full;
	assign ok = (32'(in_ch.data.taper) < 32'(MAX_TAPERS)) &&
		(32'(in_ch.data.bin) < 32'(NUM_BINS));

	always_comb begin
		q_wdata.wr    = ok;
		q_wdata.addr  = SMP_AW'(32'(in_ch.data.taper) * NUM_BINS + 32'(in_ch.data.bin));
		q_wdata.power = in_ch.data.power;
		q_wdata.start = in_ch.data.set_done;
	end
endmodule

// File: rtl/core/mtaw_queue.sv
// ----------------------------------------------------------------------------
// mtaw_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module mtaw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtaw_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output mtaw_pkg::cmd_t rdata
);
	import mtaw_pkg::*;

	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: rtl/core/mtaw_back.sv
// ----------------------------------------------------------------------------
// mtaw_back
// Sample store, estimate store and the iterative weighting sequencer.
// ----------------------------------------------------------------------------
module mtaw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  mtaw_pkg::cmd_t q_rdata,
	output logic           q_pop,
	mtaw_cfg_if.sink       cfg,
	mtaw_out_if.source     out_ch
);
	import mtaw_pkg::*;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SEED0 = 5'd1;
	localparam logic [4:0] ST_SEED1 = 5'd2;
	localparam logic [4:0] ST_SEED2 = 5'd3;
	localparam logic [4:0] ST_SUM   = 5'd4;
	localparam logic [4:0] ST_SIG   = 5'd5;
	localparam logic [4:0] ST_BIN   = 5'd6;
	localparam logic [4:0] ST_RD    = 5'd7;
	localparam logic [4:0] ST_DEN   = 5'd8;
	localparam logic [4:0] ST_KDIV  = 5'd9;
	localparam logic [4:0] ST_KSQ   = 5'd10;
	localparam logic [4:0] ST_F     = 5'd11;
	localparam logic [4:0] ST_P     = 5'd12;
	localparam logic [4:0] ST_ACC   = 5'd13;
	localparam logic [4:0] ST_FDIV  = 5'd14;
	localparam logic [4:0] ST_WB    = 5'd15;
	localparam logic [4:0] ST_EMIT  = 5'd16;
	localparam logic [4:0] ST_ERD   = 5'd17;
	localparam logic [4:0] ST_OWAIT = 5'd18;
	localparam logic [4:0] ST_OUT   = 5'd19;

	logic [4:0] st_q;
	logic [2:0] ntap_q;
	logic [15:0] lam_q [MAX_TAPERS];
	logic [BIN_W-1:0] bin_q;
	logic [TAP_W-1:0] tap_q;
	logic [RUN_W-1:0] run_q;
	logic [39:0] psum_q;
	logic [33:0] sigma_q;
	logic [31:0] s_q, x_q;
	logic [15:0] lam_r_q;
	logic [49:0] den_q;
	logic [63:0] kr_q, kd_q;
	logic [6:0] cnt_q;
	logic [23:0] k_q;
	logic [31:0] w_q;
	logic [31:0] f_q;
	logic [63:0] p_q;
	logic [35:0] hi_q;
	logic [31:0] lo_q;
	logic [34:0] fsum_q;
	logic [31:0] quo_q;
	logic [35:0] rem_q;
	logic [NUM_BINS-1:0] zf_q;
	logic [NUM_BINS-1:0] ev_q;
	logic sat_q;
	logic oval_q;
	out_item_t odata_q;
	logic [31:0] seed_a_q;

	// sample RAM
	logic smp_we;
	logic [SMP_AW-1:0] smp_wa, smp_ra;
	logic [31:0] smp_rd;
	// estimate RAM
	logic est_we;
	logic [BIN_W-1:0] est_wa, est_ra;
	logic [31:0] est_wd, est_rd, est_val;
	logic est_rv_q;

	mtaw_ram #(.WIDTH(32), .DEPTH(SMP_DEPTH)) u_smp (
		.clk(clk), .we(smp_we), .waddr(smp_wa), .wdata(q_rdata.power),
		.raddr(smp_ra), .rdata(smp_rd));
	mtaw_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_est (
		.clk(clk), .we(est_we), .waddr(est_wa), .wdata(est_wd),
		.raddr(est_ra), .rdata(est_rd));

	assign est_val = est_rv_q ? est_rd : 32'd0;

	logic idle;
	assign idle = (st_q == ST_IDLE);
	assign q_pop = idle && q_not_empty;
	assign smp_we = q_pop && q_rdata.wr;
	assign smp_wa = q_rdata.addr;
	assign cfg.ready = 1'b1;

	logic [2:0] nt_eff;
	assign nt_eff = (ntap_q < 3'd2) ? 3'd2 :
		((32'(ntap_q) > MAX_TAPERS) ? 3'(MAX_TAPERS) : ntap_q);

	logic [15:0] lam_c;
	assign lam_c = (lam_q[tap_q] > ONE_Q15) ? ONE_Q15 : lam_q[tap_q];

	logic last_tap;
	assign last_tap = (tap_q == nt_eff - 3'd1);
	logic last_bin;
	assign last_bin = (bin_q == BIN_W'(NUM_BINS - 1));

	// read addresses
	always_comb begin
		smp_ra = SMP_AW'(32'(tap_q) * NUM_BINS + 32'(bin_q));
		est_ra = bin_q;
	end

	// divider trial subtracts
	logic [64:0] kr_sh;
	assign kr_sh = {kr_q, 1'b0};
	logic [36:0] fr_sh;
	assign fr_sh = {rem_q, lo_q[31]};

	always_comb begin
		est_we = 1'b0;
		est_wa = bin_q;
		est_wd = 32'd0;
		if (st_q == ST_SEED2) begin
			est_we = 1'b1;
			est_wd = 32'((33'(seed_a_q) + 33'(smp_rd)) >> 1);
		end else if (st_q == ST_EMIT) begin
			est_we = 1'b1;
			est_wd = (fsum_q == '0) ? 32'd0 : (sat_q ? 32'hFFFFFFFF : quo_q);
		end
	end

	logic acc_pend_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_SEED1: seed_a_q <= smp_rd;
			ST_SIG: sigma_q <= 34'(psum_q >> BIN_W);
			ST_RD: begin
				s_q <= est_val;
				hi_q <= '0;
				lo_q <= '0;
				fsum_q <= '0;
			end
			ST_DEN: begin
				lam_r_q <= lam_c;
				den_q <= 50'(48'(lam_c) * 48'(s_q)) +
					50'(50'(ONE_Q15 - lam_c) * 50'(sigma_q));
				kr_q <= '0;
				kd_q <= {1'b0, s_q, 31'd0};
				cnt_q <= 7'd0;
			end
			ST_KDIV: begin
				if (65'(kr_sh | 65'(kd_q[63])) >= 65'(den_q)) begin
					kr_q <= 64'((kr_sh | 65'(kd_q[63])) - 65'(den_q));
					kd_q <= {kd_q[62:0], 1'b1};
				end else begin
					kr_q <= 64'(kr_sh | 65'(kd_q[63]));
					kd_q <= {kd_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
			end
			ST_KSQ: begin
				x_q <= smp_rd;
				if (den_q == '0) begin
					k_q <= '0;
				end else if (kd_q > 64'(KMAX)) begin
					k_q <= KMAX;
				end else begin
					k_q <= kd_q[23:0];
				end
			end
			ST_F: w_q <= 32'((48'(k_q) * 48'(k_q)) >> 16);
			ST_P: f_q <= 32'((48'(lam_r_q) * 48'(w_q)) >> 15);
			ST_ACC: p_q <= 64'(f_q) * 64'(x_q);
			ST_WB: cnt_q <= 7'd0;
			ST_FDIV: begin
				if (cnt_q == 7'd0) begin
					rem_q <= hi_q;
					sat_q <= (37'(hi_q) >= 37'(fsum_q));
					quo_q <= '0;
					cnt_q <= 7'd1;
				end else begin
					if (fr_sh >= 37'(fsum_q)) begin
						rem_q <= 36'(fr_sh - 37'(fsum_q));
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= fr_sh[35:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					lo_q <= {lo_q[30:0], 1'b0};
					cnt_q <= cnt_q + 7'd1;
				end
			end
			default: ;
		endcase
		if (st_q == ST_BIN) begin
			cnt_q <= 7'd0;
		end
		// accumulate product after it lands in p_q
		if (acc_pend_q) begin
			lo_q <= 32'(33'(lo_q) + 33'(p_q[31:0]));
			hi_q <= hi_q + 36'(p_q[63:32]) + 36'((33'(lo_q) + 33'(p_q[31:0])) >> 32);
			fsum_q <= fsum_q + 35'(f_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_pend_q <= 1'b0;
		end else begin
			acc_pend_q <= (st_q == ST_ACC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ntap_q <= 3'd2;
			for (int i = 0; i < MAX_TAPERS; i++) begin
				lam_q[i] <= ONE_Q15;
			end
			bin_q <= '0;
			tap_q <= '0;
			run_q <= '0;
			psum_q <= '0;
			zf_q <= '0;
			ev_q <= '0;
			est_rv_q <= 1'b0;
			oval_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_NUM_TAPERS) begin
					ntap_q <= cfg.wdata[2:0];
				end else begin
					lam_q[32'(cfg.index) - 32'(REG_LAMBDA0)] <= cfg.wdata;
				end
			end
			est_rv_q <= ev_q[est_ra];
			if (est_we) begin
				ev_q[est_wa] <= 1'b1;
			end
			if (oval_q && out_ch.ready) begin
				oval_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop && q_rdata.start) begin
						st_q <= ST_SEED0;
						bin_q <= '0;
						tap_q <= '0;
					end
				end
				ST_SEED0: begin
					tap_q <= 3'd1;
					st_q <= ST_SEED1;
				end
				ST_SEED1: begin
					tap_q <= 3'd0;
					st_q <= ST_SEED2;
				end
				ST_SEED2: begin
					zf_q[bin_q] <= 1'b0;
					if (last_bin) begin
						bin_q <= '0;
						run_q <= '0;
						psum_q <= '0;
						st_q <= ST_SUM;
					end else begin
						bin_q <= bin_q + 1'b1;
						st_q <= ST_SEED0;
					end
				end
				ST_SUM: begin
					// wait for the registered read of this bin's estimate
					st_q <= ST_ERD;
				end
				ST_ERD: begin
					psum_q <= psum_q + 40'(est_val);
					if (last_bin) begin
						bin_q <= '0;
						st_q <= ST_SIG;
					end else begin
						bin_q <= bin_q + 1'b1;
						st_q <= ST_SUM;
					end
				end
				ST_SIG: st_q <= ST_BIN;
				ST_BIN: begin
					tap_q <= '0;
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_DEN;
				ST_DEN: st_q <= ST_KDIV;
				ST_KDIV: begin
					if (cnt_q == 7'd63) begin
						st_q <= ST_KSQ;
					end
				end
				ST_KSQ: st_q <= ST_F;
				ST_F: st_q <= ST_P;
				ST_P: st_q <= ST_ACC;
				ST_ACC: begin
					if (last_tap) begin
						st_q <= ST_WB;
						tap_q <= '0;
					end else begin
						tap_q <= tap_q + 1'b1;
						st_q <= ST_DEN;
					end
				end
				ST_WB: begin
					// first entry: wait for accumulate, then divide
					st_q <= ST_FDIV;
				end
				ST_FDIV: begin
					if (cnt_q == 7'd32) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					zf_q[bin_q] <= (fsum_q == '0);
					if (last_bin) begin
						bin_q <= '0;
						if (32'(run_q) == RUNS - 1) begin
							st_q <= ST_OWAIT;
						end else begin
							run_q <= run_q + 1'b1;
							psum_q <= '0;
							st_q <= ST_SUM;
						end
					end else begin
						bin_q <= bin_q + 1'b1;
						st_q <= ST_BIN;
					end
				end
				ST_OWAIT: begin
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!oval_q || out_ch.ready) begin
						oval_q <= 1'b1;
						odata_q.out_bin <= bin_q;
						odata_q.psd <= est_val;
						odata_q.zero_div <= zf_q[bin_q];
						odata_q.final_bin <= last_bin;
						if (last_bin) begin
							bin_q <= '0;
							st_q <= ST_IDLE;
						end else begin
							bin_q <= bin_q + 1'b1;
							st_q <= ST_OWAIT;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = oval_q;
	assign out_ch.data = odata_q;
endmodule

// File: rtl/core/multitaper_adaptive_weighting_top.sv
// ----------------------------------------------------------------------------
// multitaper_adaptive_weighting_top
// Adaptive multitaper spectrum weighting over one set of eigenspectra.
// ----------------------------------------------------------------------------
// Channels: in_ch carries taper, bin, power and set_done; out_ch carries
// out_bin, psd, zero_div and final_bin; cfg writes num_tapers (index 0) and
// lambda_0..lambda_6 (index 1..7); the user must make these writes only
// while the block is idle, which the block itself does not enforce. A value
// without set_done is queued and written to the sample store when the
// sequencer pops it. A value with set_done starts the seed pass, then per
// run a sum pass and a weighting pass with a bit-serial weight divider; then
// 64 estimates leave one at a time, each held until the receiver takes it.
// A two-entry queue parts the input side from the sequencer, so the input
// keeps accepting while the back end is busy until the queue fills.
// A stalled receiver holds the output register and the sequencer.
// Reset empties the queue, sets num_tapers to 2, all lambdas to one, and
// clears the estimate store through per-bin valid bits.
// ----------------------------------------------------------------------------
module multitaper_adaptive_weighting_top (
	input  logic       clk,
	input  logic       arst_n,
	mtaw_in_if.sink    in_ch,
	mtaw_out_if.source out_ch,
	mtaw_cfg_if.sink   cfg
);
	import mtaw_pkg::*;

	cmd_t q_wdata, q_rdata;
	logic q_push, q_full, q_pop, q_not_empty;

	mtaw_front u_front (
		.in_ch(in_ch),
		.q_wdata(q_wdata), .q_push(q_push), .q_full(q_full));

	mtaw_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .not_empty(q_not_empty), .rdata(q_rdata));

	mtaw_back u_back (
		.clk(clk), .arst_n(arst_n), .q_not_empty(q_not_empty), .q_rdata(q_rdata),
		.q_pop(q_pop), .cfg(cfg), .out_ch(out_ch));
endmodule

// File: rtl/core/mtaw_checker.sv
// ----------------------------------------------------------------------------
// mtaw_checker
// Port-level checks of the weighting block.
// ----------------------------------------------------------------------------
module mtaw_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [5:0] out_bin,
	input logic [31:0] psd,
	input logic zero_div,
	input logic final_bin
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(psd))
		else $error("output dropped under stall");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_div |-> psd == 32'd0)
		else $error("zero_div with nonzero psd");
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_bin |-> out_bin == 6'd63)
		else $error("final_bin on wrong bin");
endmodule

bind multitaper_adaptive_weighting_top mtaw_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_bin(out_ch.data.out_bin), .psd(out_ch.data.psd),
	.zero_div(out_ch.data.zero_div), .final_bin(out_ch.data.final_bin));
